// File: rtl/ffmp_pkg.sv
package ffmp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_KNOWN_CLASS = 2'd2;

    // Register reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h62;
    localparam logic [7:0] KNOWN_CLASS_RST = 8'h05;

    // Known ids within the accepted class
    localparam logic [7:0] ID_NAK = 8'h00;
    localparam logic [7:0] ID_ACK = 8'h01;

    // Result kind
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CKSUM    = 2'd1,
        ST_UNKNOWN  = 2'd2
    } t_status;

endpackage

// File: rtl/fletcher_framed_message_parser.sv
// A payload or second checksum byte shows its result word in the cycle after it is taken.
// Throughput: one byte per cycle unless a word waits untaken; the result register drains while
//   the next byte enters, and parse state and both Fletcher sums update as the byte is taken.
// Reset (synchronous, active low): parser hunts for the first sync byte, sums and frame
//   fields clear, sync/class registers return to B5h, 62h and 05h, no result pending.
module fletcher_framed_message_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [7:0]           o_data_byte,
    output logic [15:0]          o_byte_index,
    output logic [7:0]           o_msg_class,
    output logic [7:0]           o_msg_id,
    output logic [15:0]          o_msg_length,
    output ffmp_pkg::t_status    o_frame_status,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import ffmp_pkg::*;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_phase;

    // configuration
    logic [7:0]  r_sync_first, r_sync_second, r_known_class;

    // parse state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_rcv_a, n_rcv_a;

    // result register
    logic        r_out_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_data, n_data;
    logic [15:0] r_index, n_index;
    logic [7:0]  r_res_class, r_res_id;
    logic [15:0] r_res_len;
    t_status     r_status, n_status;
    logic        n_emit;

    logic        in_fire;
    logic [7:0]  fold_a;     // sum A after folding in this byte
    logic [7:0]  base_a, base_b;
    logic [15:0] seen_inc;

    // The result register is free when empty or being taken this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Sums restart on the class byte.
    assign base_a   = (r_phase == PH_CLASS) ? 8'd0 : r_sum_a;
    assign base_b   = (r_phase == PH_CLASS) ? 8'd0 : r_sum_b;
    assign fold_a   = base_a + i_rx_byte;
    assign seen_inc = r_seen + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_class  = r_class;
        n_id     = r_id;
        n_len    = r_len;
        n_seen   = r_seen;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_rcv_a  = r_rcv_a;
        n_emit   = 1'b0;
        n_kind   = KIND_PAYLOAD;
        n_data   = 8'd0;
        n_index  = 16'd0;
        n_status = ST_OK;
        unique case (r_phase)
            PH_SYNC1: begin
                if (i_rx_byte == r_sync_first) n_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                // a repeated first sync byte keeps us waiting for the second
                if (i_rx_byte == r_sync_second)     n_phase = PH_CLASS;
                else if (i_rx_byte != r_sync_first) n_phase = PH_SYNC1;
            end
            PH_CLASS: begin
                n_sum_a = fold_a;
                n_sum_b = base_b + fold_a;
                n_class = i_rx_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_sum_a = fold_a;
                n_sum_b = base_b + fold_a;
                n_id    = i_rx_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_sum_a = fold_a;
                n_sum_b = base_b + fold_a;
                n_len   = {8'd0, i_rx_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_sum_a = fold_a;
                n_sum_b = base_b + fold_a;
                n_len   = {i_rx_byte, r_len[7:0]};
                n_seen  = 16'd0;
                // empty payload goes straight to the checksum
                n_phase = ({i_rx_byte, r_len[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum_a = fold_a;
                n_sum_b = base_b + fold_a;
                n_emit  = 1'b1;
                n_kind  = KIND_PAYLOAD;
                n_data  = i_rx_byte;
                n_index = r_seen;
                n_seen  = seen_inc;
                if (seen_inc == r_len) n_phase = PH_CK_A;
            end
            PH_CK_A: begin
                n_rcv_a = i_rx_byte;
                n_phase = PH_CK_B;
            end
            PH_CK_B: begin
                n_emit = 1'b1;
                n_kind = KIND_FRAME_END;
                // checksum failure outranks an unknown message
                priority if (r_rcv_a != r_sum_a || i_rx_byte != r_sum_b) begin
                    n_status = ST_CKSUM;
                end else if (r_class != r_known_class ||
                             (r_id != ID_NAK && r_id != ID_ACK)) begin
                    n_status = ST_UNKNOWN;
                end else begin
                    n_status = ST_OK;
                end
                n_phase = PH_SYNC1;
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_known_class <= KNOWN_CLASS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                CFG_KNOWN_CLASS: r_known_class <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse state, advanced once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_class <= 8'd0;
            r_id    <= 8'd0;
            r_len   <= 16'd0;
            r_seen  <= 16'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_rcv_a <= 8'd0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_rcv_a <= n_rcv_a;
        end
    end

    // result register: valid is control, payload loads with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_kind      <= n_kind;
            r_data      <= n_data;
            r_index     <= n_index;
            r_res_class <= r_class;
            r_res_id    <= r_id;
            r_res_len   <= r_len;
            r_status    <= n_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_byte_index     = r_index;
    assign o_msg_class      = r_res_class;
    assign o_msg_id         = r_res_id;
    assign o_msg_length     = r_res_len;
    assign o_frame_status   = r_status;

`ifndef NO_ASSERTIONS
    // In payload phase the count never reaches the declared length.
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_seen != r_len)
        else $error("payload count reached declared length while in payload phase");

    // A checksum byte B always yields a frame-end word next cycle.
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_phase == PH_CK_B) |=> (r_out_valid && r_kind == KIND_FRAME_END))
        else $error("frame end word missing after second checksum byte");

    // A payload byte always yields a payload word next cycle.
    a_payload_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_phase == PH_PAYLOAD) |=> (r_out_valid && r_kind == KIND_PAYLOAD))
        else $error("payload word missing after payload byte");

    // Payload words carry status ok; frame-end words carry zero data and index.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_kind == KIND_PAYLOAD && r_status == ST_OK) ||
                         (r_kind == KIND_FRAME_END && r_data == 8'd0 &&
                          r_index == 16'd0)))
        else $error("result word fields inconsistent with kind");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ffmp_pkg::*;

    // Word expected on the result channel: one per payload byte, one per frame end
    typedef struct {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] pos;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        t_status     status;
    } t_parse_word;

    typedef enum logic [3:0] {
        PH_HUNT, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
        PH_PAYLOAD, PH_CK_A, PH_CK_B
    } t_parse_phase;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 3;
    localparam int MAX_GAP        = 17;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_kind;
    logic [7:0]  o_data_byte;
    logic [15:0] o_byte_index;
    logic [7:0]  o_msg_class;
    logic [7:0]  o_msg_id;
    logic [15:0] o_msg_length;
    t_status     o_frame_status;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    fletcher_framed_message_parser DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_byte_index     (o_byte_index),
        .o_msg_class      (o_msg_class),
        .o_msg_id         (o_msg_id),
        .o_msg_length     (o_msg_length),
        .o_frame_status   (o_frame_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Parser mirror: tracks the block's registers and frame state, updated
    // at every edge where the block takes a byte or a register write.
    // ------------------------------------------------------------------
    logic [7:0]   sync1_reg;
    logic [7:0]   sync2_reg;
    logic [7:0]   class_reg;
    t_parse_phase phase;
    logic [7:0]   frame_cls;
    logic [7:0]   frame_id;
    logic [15:0]  frame_len;
    logic [15:0]  payload_pos;
    logic [7:0]   sum_a;
    logic [7:0]   sum_b;
    logic [7:0]   rcvd_ck_a;

    t_parse_word parsed_words[$];

    int error_count;
    int idle_cycles;

    // Stimulus side: current register values, used to build frames
    logic [7:0] cur_sync1;
    logic [7:0] cur_sync2;
    logic [7:0] cur_class;
    int         bytes_sent;
    bit         tx_idle;
    bit         rx_idle;

    task automatic clear_parser();
        sync1_reg   = SYNC_FIRST_RST;
        sync2_reg   = SYNC_SECOND_RST;
        class_reg   = KNOWN_CLASS_RST;
        phase       = PH_HUNT;
        frame_cls   = 8'h00;
        frame_id    = 8'h00;
        frame_len   = 16'h0000;
        payload_pos = 16'h0000;
        sum_a       = 8'h00;
        sum_b       = 8'h00;
        rcvd_ck_a   = 8'h00;
    endtask

    // Advance the mirror by one byte and queue the word it produces, if any
    task automatic parse_byte(input logic [7:0] b);
        t_parse_word w;
        w.kind   = KIND_PAYLOAD;
        w.data   = 8'h00;
        w.pos    = 16'h0000;
        w.status = ST_OK;
        case (phase)
            PH_HUNT: begin
                if (b == sync1_reg) phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                // a repeated first sync byte keeps us waiting for the second
                if (b == sync2_reg) phase = PH_CLASS;
                else if (b != sync1_reg) phase = PH_HUNT;
            end
            PH_CLASS: begin
                sum_a     = b;
                sum_b     = b;
                frame_cls = b;
                phase     = PH_ID;
            end
            PH_ID: begin
                sum_a    = sum_a + b;
                sum_b    = sum_b + sum_a;
                frame_id = b;
                phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                sum_a     = sum_a + b;
                sum_b     = sum_b + sum_a;
                frame_len = {8'h00, b};
                phase     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                sum_a       = sum_a + b;
                sum_b       = sum_b + sum_a;
                frame_len   = {b, frame_len[7:0]};
                payload_pos = 16'h0000;
                // empty payload goes straight to the checksum
                phase       = (frame_len == 16'h0000) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                sum_a  = sum_a + b;
                sum_b  = sum_b + sum_a;
                w.data = b;
                w.pos  = payload_pos;
                w.cls  = frame_cls;
                w.id   = frame_id;
                w.len  = frame_len;
                parsed_words.push_back(w);
                payload_pos = payload_pos + 16'd1;
                if (payload_pos == frame_len) phase = PH_CK_A;
            end
            PH_CK_A: begin
                rcvd_ck_a = b;
                phase     = PH_CK_B;
            end
            PH_CK_B: begin
                // checksum failure outranks an unknown class or id
                if (rcvd_ck_a != sum_a || b != sum_b)
                    w.status = ST_CKSUM;
                else if (frame_cls != class_reg ||
                         (frame_id != ID_NAK && frame_id != ID_ACK))
                    w.status = ST_UNKNOWN;
                else
                    w.status = ST_OK;
                w.kind = KIND_FRAME_END;
                w.cls  = frame_cls;
                w.id   = frame_id;
                w.len  = frame_len;
                parsed_words.push_back(w);
                phase = PH_HUNT;
            end
            default: phase = PH_HUNT;
        endcase
    endtask

    task automatic check_word();
        t_parse_word w;
        if (parsed_words.size() == 0) begin
            $error("result word with none expected: kind %0d data %02h index %0d",
                   o_kind, o_data_byte, o_byte_index);
            error_count++;
        end else begin
            w = parsed_words.pop_front();
            if (o_kind !== w.kind) begin
                $error("kind: expected %0d, got %0d", w.kind, o_kind);
                error_count++;
            end
            if (o_data_byte !== w.data) begin
                $error("data_byte: expected %02h, got %02h", w.data, o_data_byte);
                error_count++;
            end
            if (o_byte_index !== w.pos) begin
                $error("byte_index: expected %0d, got %0d", w.pos, o_byte_index);
                error_count++;
            end
            if (o_msg_class !== w.cls) begin
                $error("msg_class: expected %02h, got %02h", w.cls, o_msg_class);
                error_count++;
            end
            if (o_msg_id !== w.id) begin
                $error("msg_id: expected %02h, got %02h", w.id, o_msg_id);
                error_count++;
            end
            if (o_msg_length !== w.len) begin
                $error("msg_length: expected %0d, got %0d", w.len, o_msg_length);
                error_count++;
            end
            if (o_frame_status !== w.status) begin
                $error("frame_status: expected %0d, got %0d", w.status, o_frame_status);
                error_count++;
            end
        end
    endtask

    // Monitor: everything sampled on the rising edge, before the block updates.
    // Register writes and bytes never share an edge in this bench.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            idle_cycles = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:  sync1_reg = i_cfg_data;
                    CFG_SYNC_SECOND: sync2_reg = i_cfg_data;
                    CFG_KNOWN_CLASS: class_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) parse_byte(i_rx_byte);
            if (o_out_valid && i_out_ready) check_word();

            if (i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Gap before a word; at least a third of the time zero even when idling is on
    function automatic int draw_gap(input bit idle_on);
        if (!idle_on) return 0;
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Result side: stall for a drawn number of cycles, then hold ready until a word moves
    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            stall = draw_gap(rx_idle);
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One byte on the input channel; valid is left high after acceptance so
    // back-to-back words need no toggle
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(tx_idle);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_byte  = b;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        bytes_sent++;
    endtask

    // Stop sending, let all expected words drain, then give the block a few
    // cycles in case the last byte produced no word
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (parsed_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  cur_sync1 = val;
            CFG_SYNC_SECOND: cur_sync2 = val;
            CFG_KNOWN_CLASS: cur_class = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] kc);
        settle();
        write_reg(CFG_SYNC_FIRST, s1);
        write_reg(CFG_SYNC_SECOND, s2);
        write_reg(CFG_KNOWN_CLASS, kc);
    endtask

    // Build and send a frame with the current sync bytes.
    //   fill     : payload byte value, negative for random payload
    //   cut      : bytes actually sent, negative for the whole frame
    //   pause_at : byte position before which the stream goes quiet, negative for none
    //   bad_a/b  : corrupt the first / second checksum byte
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input int fill, input int cut,
                              input int pause_at, input bit bad_a, input bit bad_b);
        logic [7:0] frame_bytes[$];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] pb;
        logic [7:0] flip;
        int         n;
        frame_bytes = {cur_sync1, cur_sync2, cls, id, len[7:0], len[15:8]};
        ck_a = 8'h00;
        ck_b = 8'h00;
        for (int k = 2; k < 6; k++) begin
            ck_a = ck_a + frame_bytes[k];
            ck_b = ck_b + ck_a;
        end
        for (int k = 0; k < int'(len); k++) begin
            if (fill < 0) pb = 8'($urandom_range(0, 255));
            else pb = 8'(fill);
            ck_a = ck_a + pb;
            ck_b = ck_b + ck_a;
            frame_bytes.push_back(pb);
        end
        flip = bad_a ? 8'($urandom_range(1, 255)) : 8'h00;
        frame_bytes.push_back(ck_a ^ flip);
        flip = bad_b ? 8'($urandom_range(1, 255)) : 8'h00;
        frame_bytes.push_back(ck_b ^ flip);

        n = (cut < 0) ? frame_bytes.size() : cut;
        for (int k = 0; k < n; k++) begin
            if (k == pause_at) settle();
            send_byte(frame_bytes[k]);
        end
    endtask

    // Random frame; a broken one stops after the first sync byte or somewhere
    // past the header so the following traffic completes it
    task automatic send_random_frame(input bit broken);
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        int          cut;
        int          total;
        cls = ($urandom_range(0, 9) < 6) ? cur_class : 8'($urandom_range(0, 255));
        id  = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 1))
                                         : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 39) == 0)
            len = 16'($urandom_range(256, 300));
        else if ($urandom_range(0, 9) == 0)
            len = 16'($urandom_range(9, 48));
        else
            len = 16'($urandom_range(0, 8));
        total = 8 + int'(len);
        cut   = -1;
        if (broken)
            cut = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(6, total - 1);
        send_frame(cls, id, len, -1, cut, -1,
                   $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hunting: noise, a repeated first sync byte, a wrong second sync byte,
    // then a clean acknowledge frame
    task automatic test_sync_hunt();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cur_sync1);
        send_byte(cur_sync1);
        send_byte(8'h13);
        send_frame(cur_class, ID_ACK, 16'd2, 8'hFF, -1, -1, 1'b0, 1'b0);
    endtask

    // Every status, empty payload, extreme class/id values, checksum priority
    task automatic test_frame_status();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_frame(cur_class, ID_NAK, 16'd0, -1, -1, -1, 1'b0, 1'b0);
        send_frame(8'hFF, ID_ACK, 16'd1, 8'h00, -1, -1, 1'b0, 1'b0);
        send_frame(cur_class, 8'h02, 16'd1, 8'hFF, -1, -1, 1'b0, 1'b0);
        send_frame(8'h00, 8'hFF, 16'd0, -1, -1, -1, 1'b0, 1'b0);
        send_frame(cur_class, ID_ACK, 16'd2, -1, -1, -1, 1'b1, 1'b0);
        send_frame(cur_class, ID_NAK, 16'd1, -1, -1, -1, 1'b0, 1'b1);
        // mismatch on a frame that is also unknown: mismatch wins
        send_frame(8'h77, 8'h09, 16'd1, -1, -1, -1, 1'b1, 1'b1);
    endtask

    // Stream goes quiet mid-sync and mid-payload; parser must just wait
    task automatic test_partial_frame();
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        send_frame(cur_class, ID_ACK, 16'd3, -1, -1, 1, 1'b0, 1'b0);
        send_frame(cur_class, ID_NAK, 16'd3, -1, -1, 7, 1'b0, 1'b0);
    endtask

    // Several register settings, extremes included, each with random traffic:
    // mostly well-formed frames, some noise and some cut-off frames
    task automatic test_random_traffic();
        int stop_at;
        int pick;
        int noise_len;
        logic [7:0] nb;
        for (int setting = 0; setting < 5; setting++) begin
            case (setting)
                0: set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, KNOWN_CLASS_RST);
                1: set_config(8'h00, 8'hFF, 8'hFF);
                2: set_config(8'hFF, 8'h00, 8'h00);
                3: set_config(8'h3C, 8'h3C, 8'($urandom_range(0, 255)));
                default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            stop_at = bytes_sent + 115;
            while (bytes_sent < stop_at) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    send_random_frame(1'b0);
                end else if (pick < 87) begin
                    noise_len = $urandom_range(1, 6);
                    repeat (noise_len) begin
                        nb = ($urandom_range(0, 2) == 0) ? cur_sync1
                                                         : 8'($urandom_range(0, 255));
                        // with equal sync bytes a stray one would open a frame whose
                        // length comes from the next header; keep those out of noise
                        if (cur_sync1 == cur_sync2 && nb == cur_sync1) nb = ~nb;
                        send_byte(nb);
                    end
                end else begin
                    send_random_frame(1'b1);
                end
            end
        end
    endtask

    // Declared length with a nonzero high byte, run without idling
    task automatic test_long_frame();
        set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, KNOWN_CLASS_RST);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_frame(cur_class, ID_ACK, 16'h0100, -1, -1, -1, 1'b0, 1'b0);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = 8'h00;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_SYNC_FIRST;
        i_cfg_data  = 8'h00;
        cur_sync1   = SYNC_FIRST_RST;
        cur_sync2   = SYNC_SECOND_RST;
        cur_class   = KNOWN_CLASS_RST;
        bytes_sent  = 0;
        error_count = 0;
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_sync_hunt();
        test_frame_status();
        test_partial_frame();
        test_random_traffic();
        test_long_frame();

        // drain and let the last byte settle
        settle();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
